// File: design/neighbor_table_with_aging_macros.svh
// assertion macros for the neighbor table checker
// used by nta_checker, needs i_clk and i_rst_n in scope
`ifndef NEIGHBOR_TABLE_WITH_AGING_MACROS_SVH
`define NEIGHBOR_TABLE_WITH_AGING_MACROS_SVH

// checked only while out of reset
`define NTA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("neighbor table assertion failed");

// checked on every edge, reset included
`define NTA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("neighbor table assertion failed");

`endif

// File: design/nta_pkg.sv
// shared types, constants and helpers of the neighbor table with aging
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nta_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int NUM_IFACES        = 4;
    localparam int EXPIRY_FACTOR     = 3;

    localparam int IFACE_W = 2;
    localparam int IP_W    = 32;
    localparam int CFG_W   = 8;
    localparam int AGE_W   = 10;
    localparam int OUT_W   = 5;
    // sized for the largest table the block supports
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;

    localparam logic [AGE_W-1:0] AGE_MAX        = '1;
    localparam logic [CFG_W-1:0] HELLO_INTV_RST = 8'd5;

    typedef enum logic [0:0] {
        CMD_HELLO = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_REFRESH = 2'd0,
        STAT_INSERT  = 2'd1,
        STAT_DROP    = 2'd2,
        STAT_TICK    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    // request broadcast to all cells while it walks
    typedef struct packed {
        t_cmd              op;
        logic [IFACE_W-1:0] iface;
        logic [IP_W-1:0]    ip;
        logic [IP_W-1:0]    rid;
        logic [IP_W-1:0]    mask;
        logic [AGE_W-1:0]   limit;
    } t_req;

    // token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] expired;
    } t_tok;

    // entry write after a hello walk
    typedef struct packed {
        logic             en;
        logic             insert;
        logic [IDX_W-1:0] idx;
    } t_wr;

    function automatic logic [OUT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'({OUT_W{1'b1}});
        return (v > lim) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/nta_cell.sv
// one neighbor entry of the table, ages or matches as the token passes
// depends on nta_pkg
`timescale 1ns / 1ps
`default_nettype none

module nta_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire nta_pkg::t_req i_req,
    input  wire nta_pkg::t_wr  i_wr,
    input  wire nta_pkg::t_tok i_tok,
    output nta_pkg::t_tok      o_tok
);

    logic                          r_valid, n_valid;
    logic [nta_pkg::IFACE_W-1:0]   r_iface, n_iface;
    logic [nta_pkg::IP_W-1:0]      r_ip, n_ip;
    logic [nta_pkg::IP_W-1:0]      r_router, n_router;
    logic [nta_pkg::IP_W-1:0]      r_mask, n_mask;
    logic [nta_pkg::AGE_W-1:0]     r_age, n_age;
    nta_pkg::t_tok                 r_tok, n_tok;
    logic                          wr_here;

    assign wr_here = i_wr.en && (i_wr.idx == nta_pkg::IDX_W'(CELL_IDX));

    always_comb begin
        n_tok    = i_tok;
        n_valid  = r_valid;
        n_iface  = r_iface;
        n_ip     = r_ip;
        n_router = r_router;
        n_mask   = r_mask;
        n_age    = r_age;
        if (i_tok.valid) begin
            if (i_req.op == nta_pkg::CMD_TICK) begin
                if (r_valid) begin
                    if (r_age > i_req.limit) begin
                        n_valid       = 1'b0;
                        n_tok.expired = i_tok.expired + 1'b1;
                    end else begin
                        if (r_age != nta_pkg::AGE_MAX) begin
                            n_age = r_age + 1'b1;
                        end
                        if (r_iface == i_req.iface) begin
                            n_tok.count = i_tok.count + 1'b1;
                        end
                    end
                end
            end else begin
                if (r_valid) begin
                    if (r_iface == i_req.iface) begin
                        n_tok.count = i_tok.count + 1'b1;
                        if (!i_tok.hit && (r_ip == i_req.ip)) begin
                            n_tok.hit     = 1'b1;
                            n_tok.hit_idx = nta_pkg::IDX_W'(CELL_IDX);
                        end
                    end
                end else if (!i_tok.free) begin
                    n_tok.free     = 1'b1;
                    n_tok.free_idx = nta_pkg::IDX_W'(CELL_IDX);
                end
            end
        end
        if (wr_here) begin
            n_age = '0;
            if (i_wr.insert) begin
                n_valid  = 1'b1;
                n_iface  = i_req.iface;
                n_ip     = i_req.ip;
                n_router = i_req.rid;
                n_mask   = i_req.mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iface  <= n_iface;
        r_ip     <= n_ip;
        r_router <= n_router;
        r_mask   <= n_mask;
        r_age    <= n_age;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: design/neighbor_table_with_aging.sv
// a request is registered and injects a token that walks the chain of entry cells,
// one cell per cycle; the token at the end of the chain is registered, and the result
// is then loaded into the output register; one request is in the table at a time,
// but a new request is taken while the previous result still waits at the output
// reset: synchronous active low, clears all entries and sets hello_interval to 5
// top level of the neighbor table, depends on nta_pkg and nta_cell
`timescale 1ns / 1ps
`default_nettype none

module neighbor_table_with_aging #(
    parameter int TABLE_ENTRIES = nta_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [0:0]                    i_cmd,
    input  wire logic [nta_pkg::IFACE_W-1:0]   i_iface_sel,
    input  wire logic [nta_pkg::IP_W-1:0]      i_sender_ip,
    input  wire logic [nta_pkg::IP_W-1:0]      i_router_ident,
    input  wire logic [nta_pkg::IP_W-1:0]      i_net_mask,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_status,
    output logic [nta_pkg::OUT_W-1:0]          o_iface_count,
    output logic [nta_pkg::OUT_W-1:0]          o_expired_count,
    input  wire logic                          i_cfg_we,
    input  wire logic [nta_pkg::CFG_W-1:0]     i_cfg_data
);

    nta_pkg::t_state               r_state, n_state;
    nta_pkg::t_req                 r_req, n_req;
    nta_pkg::t_tok                 r_inj, n_inj;
    nta_pkg::t_tok                 r_fin, n_fin;
    logic [nta_pkg::CFG_W-1:0]     r_hello, n_hello;
    logic                          r_out_valid, n_out_valid;
    nta_pkg::t_status              r_status, n_status;
    logic [nta_pkg::OUT_W-1:0]     r_cnt, n_cnt;
    logic [nta_pkg::OUT_W-1:0]     r_exp, n_exp;

    nta_pkg::t_tok                 tok [0:TABLE_ENTRIES];
    nta_pkg::t_wr                  wr;
    logic                          accept;
    logic                          fire;
    logic                          iface_bad;

    assign tok[0] = r_inj;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        nta_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_req  (r_req),
            .i_wr   (wr),
            .i_tok  (tok[g]),
            .o_tok  (tok[g+1])
        );
    end

    assign iface_bad = (5'(r_req.iface) >= 5'(nta_pkg::NUM_IFACES));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nta_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = nta_pkg::ST_WALK;
                end
            end
            nta_pkg::ST_WALK: begin
                if (tok[TABLE_ENTRIES].valid) begin
                    n_state = nta_pkg::ST_FINISH;
                end
            end
            nta_pkg::ST_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    n_state = nta_pkg::ST_IDLE;
                end
            end
            default: n_state = nta_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_ready     = (r_state == nta_pkg::ST_IDLE);
        accept      = i_valid && o_ready;
        fire        = (r_state == nta_pkg::ST_FINISH) && (!r_out_valid || i_ready);
        n_hello     = i_cfg_we ? i_cfg_data : r_hello;
        n_req       = r_req;
        n_inj       = '0;
        n_fin       = r_fin;
        wr          = '0;
        n_status    = r_status;
        n_cnt       = r_cnt;
        n_exp       = r_exp;
        n_out_valid = fire ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);

        if (accept) begin
            n_req.op    = nta_pkg::t_cmd'(i_cmd);
            n_req.iface = i_iface_sel;
            n_req.ip    = i_sender_ip;
            n_req.rid   = i_router_ident;
            n_req.mask  = i_net_mask;
            n_req.limit = nta_pkg::AGE_W'(nta_pkg::EXPIRY_FACTOR)
                          * nta_pkg::AGE_W'(r_hello);
            n_inj.valid = 1'b1;
        end

        if ((r_state == nta_pkg::ST_WALK) && tok[TABLE_ENTRIES].valid) begin
            n_fin = tok[TABLE_ENTRIES];
        end

        if (fire) begin
            n_exp = '0;
            n_cnt = iface_bad ? '0 : nta_pkg::sat_count(r_fin.count);
            if (r_req.op == nta_pkg::CMD_TICK) begin
                n_status = nta_pkg::STAT_TICK;
                n_exp    = nta_pkg::sat_count(r_fin.expired);
            end else if (iface_bad) begin
                n_status = nta_pkg::STAT_DROP;
            end else if (r_fin.hit) begin
                n_status = nta_pkg::STAT_REFRESH;
                wr.en    = 1'b1;
                wr.idx   = r_fin.hit_idx;
            end else if (r_fin.free) begin
                n_status  = nta_pkg::STAT_INSERT;
                wr.en     = 1'b1;
                wr.insert = 1'b1;
                wr.idx    = r_fin.free_idx;
                n_cnt     = nta_pkg::sat_count(r_fin.count + 1'b1);
            end else begin
                n_status = nta_pkg::STAT_DROP;
            end
        end

        o_valid         = r_out_valid;
        o_status        = r_status;
        o_iface_count   = r_cnt;
        o_expired_count = r_exp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nta_pkg::ST_IDLE;
            r_inj       <= '0;
            r_hello     <= nta_pkg::HELLO_INTV_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_inj       <= n_inj;
            r_hello     <= n_hello;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_fin    <= n_fin;
        r_status <= n_status;
        r_cnt    <= n_cnt;
        r_exp    <= n_exp;
    end

endmodule

`default_nettype wire

// File: design/nta_checker.sv
// port-level checks of the neighbor table, bound to the top level
// depends on nta_pkg and neighbor_table_with_aging_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "neighbor_table_with_aging_macros.svh"

module nta_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_ready,
    input wire logic                        o_valid,
    input wire logic                        i_ready,
    input wire logic [1:0]                  o_status,
    input wire logic [nta_pkg::OUT_W-1:0]   o_iface_count,
    input wire logic [nta_pkg::OUT_W-1:0]   o_expired_count
);

    // result register empty after reset
    `NTA_ASSERT_ALWAYS(a_reset_out, !i_rst_n |=> !o_valid)

    // one request at a time while the chain is walked
    `NTA_ASSERT(a_busy_after_accept, (i_valid && o_ready) |=> !o_ready)

    // hellos never remove entries
    `NTA_ASSERT(a_hello_no_expiry,
        (o_valid && (o_status != nta_pkg::STAT_TICK)) |-> (o_expired_count == '0))

    // an inserted neighbor is counted on its interface
    `NTA_ASSERT(a_insert_counted,
        (o_valid && (o_status == nta_pkg::STAT_INSERT)) |-> (o_iface_count != '0))

    // stalled result holds
    `NTA_ASSERT(a_out_hold,
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)
            && $stable(o_iface_count) && $stable(o_expired_count)))

endmodule

bind neighbor_table_with_aging nta_checker u_nta_checker (.*);

`default_nettype wire
